[sv/mket_pkg.sv]
// ----------------------------------------------------------------------------
// mket_pkg: shared types and constants of the Morse keyer element timer
// Command codes, field widths, divider lanes and the controller/datapath
// command and status words.
// ----------------------------------------------------------------------------
package mket_pkg;

    // Input command codes
    typedef enum logic [2:0] {
        CMD_TICK         = 3'd0,
        CMD_PADDLE_START = 3'd1,
        CMD_PADDLE_STOP  = 3'd2,
        CMD_KEY_DOWN     = 3'd3,
        CMD_KEY_UP       = 3'd4,
        CMD_ENTER        = 3'd5,
        CMD_FINISH       = 3'd6
    } cmd_t;

    // Configuration register indexes (byte address bit 2)
    localparam logic REG_WPM  = 1'b0;
    localparam logic REG_TICK = 1'b1;

    // Field and state widths
    localparam int CMD_W   = 3;
    localparam int WPM_W   = 6;
    localparam int TICK_W  = 7;
    localparam int MS_W    = 16;
    localparam int DIT_W   = 11;
    localparam int PHASE_W = 12;
    localparam int PAT_W   = 8;
    localparam int PAT_IDX_W = $clog2(PAT_W);
    localparam int CNT_W   = 4;

    localparam int MAX_ELEMENTS = 8;
    localparam int CAPACITY = (MAX_ELEMENTS > 15) ? 15 : MAX_ELEMENTS;

    localparam logic [WPM_W-1:0] DEFAULT_WPM  = 6'd15;
    localparam logic [TICK_W-1:0] DEFAULT_TICK = 7'd10;
    localparam logic [DIT_W-1:0] DEFAULT_DIT  = 11'd80;

    // Divider: three constant dividends over the effective wpm
    localparam int DIV_W     = 12;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int DIV_LANES = 3;
    localparam int LANE_DIT  = 0;
    localparam int LANE_DAH  = 1;
    localparam int LANE_GAP  = 2;
    localparam logic [DIV_W-1:0] DIVIDENDS [DIV_LANES] = '{12'd1200, 12'd2400, 12'd3600};

    // Controller to datapath/divider
    typedef struct packed {
        logic capture;
        logic div_start;
        logic exec;
    } ctrl_cmd_t;

    // Datapath/divider to controller
    typedef struct packed {
        logic div_done;
        logic out_free;
    } ctrl_sts_t;

endpackage

[sv/mket_div.sv]
// ----------------------------------------------------------------------------
// mket_div: radix-2 restoring divider, three constant dividends
// Divides 1200, 2400 and 3600 by the effective wpm in parallel lanes,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mket_div import mket_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WPM_W-1:0]     divisor,
    output logic                 done,
    output logic [DIV_W-1:0]     quo_dit,
    output logic [DIV_W-1:0]     quo_dah,
    output logic [DIV_W-1:0]     quo_gap
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [WPM_W-1:0]     rem_reg  [DIV_LANES];
    logic [DIV_W-1:0]     quo_reg  [DIV_LANES];
    logic [WPM_W-1:0]     rem_next [DIV_LANES];
    logic [DIV_W-1:0]     quo_next [DIV_LANES];
    logic [DIV_CNT_W-1:0] bit_idx;

    // Select the dividend bit for this step, most significant first
    assign bit_idx = DIV_CNT_W'(DIV_W - 1) - cnt_reg;

    // Trial subtract in each lane
    always_comb
    begin
        logic [WPM_W:0] trial;
        for (int i = 0; i < DIV_LANES; i++)
        begin
            trial = {rem_reg[i], DIVIDENDS[i][bit_idx]};
            if (trial >= {1'b0, divisor})
            begin
                rem_next[i] = WPM_W'(trial - {1'b0, divisor});
                quo_next[i] = {quo_reg[i][DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = trial[WPM_W-1:0];
                quo_next[i] = {quo_reg[i][DIV_W-2:0], 1'b0};
            end
        end
    end

    // Sequence the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Hold partial remainders and quotients
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DIV_LANES; i++)
        begin
            if (start)
            begin
                rem_reg[i] <= '0;
                quo_reg[i] <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
            end
        end
    end

    assign done    = done_reg;
    assign quo_dit = quo_reg[LANE_DIT];
    assign quo_dah = quo_reg[LANE_DAH];
    assign quo_gap = quo_reg[LANE_GAP];

endmodule

[sv/mket_dp.sv]
// ----------------------------------------------------------------------------
// mket_dp: keyer datapath
// Holds the captured word, the keyer state and the output register, and
// applies one command per exec pulse.
// ----------------------------------------------------------------------------
module mket_dp import mket_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            cmd,
    output logic                 out_free,
    input  logic [CMD_W-1:0]     command,
    input  logic                 element_kind,
    input  logic [TICK_W-1:0]    tick_period,
    input  logic [DIV_W-1:0]     quo_dit,
    input  logic [DIV_W-1:0]     quo_dah,
    input  logic [DIV_W-1:0]     quo_gap,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic                 tone_on,
    output logic                 element_valid,
    output logic                 element_is_dah,
    output logic                 char_valid,
    output logic [PAT_W-1:0]     char_pattern,
    output logic [CNT_W-1:0]     char_length
);

    // Captured word
    logic [CMD_W-1:0]   item_cmd_reg;
    logic               item_kind_reg;

    // Keyer state
    logic               key_held_reg,       key_held_next;
    logic [MS_W-1:0]    key_held_ms_reg,    key_held_ms_next;
    logic               running_reg,        running_next;
    logic               stop_reg,           stop_next;
    logic               mark_reg,           mark_next;
    logic               paddle_kind_reg,    paddle_kind_next;
    logic [DIT_W-1:0]   dit_reg,            dit_next;
    logic [PHASE_W-1:0] phase_reg,          phase_next;
    logic               any_seen_reg,       any_seen_next;
    logic [MS_W-1:0]    since_reg,          since_next;
    logic [PAT_W-1:0]   pat_reg,            pat_next;
    logic [CNT_W-1:0]   count_reg,          count_next;

    // Output register
    logic               out_valid_reg;
    logic               tone_reg;
    logic               elem_valid_reg;
    logic               elem_dah_reg;
    logic               chr_valid_reg;
    logic [PAT_W-1:0]   chr_pat_reg;
    logic [CNT_W-1:0]   chr_len_reg;

    // Result of the current word
    logic               res_tone;
    logic               res_elem_valid;
    logic               res_elem_dah;
    logic               res_chr_valid;
    logic [PAT_W-1:0]   res_chr_pat;
    logic [CNT_W-1:0]   res_chr_len;

    logic [MS_W-1:0]    gap_ms;
    logic [MS_W-1:0]    dah_ms;

    assign gap_ms = {{(MS_W-DIV_W){1'b0}}, quo_gap};
    assign dah_ms = {{(MS_W-DIV_W){1'b0}}, quo_dah};

    // Apply one command to the keyer state
    always_comb
    begin
        cmd_t               op;
        logic [MS_W:0]      since_sum;
        logic [MS_W:0]      held_sum;
        logic [PHASE_W:0]   dit_triple;
        logic               begin_el;
        logic               key_do;
        logic               key_dah;

        op         = cmd_t'(item_cmd_reg);
        since_sum  = {1'b0, since_reg} + (MS_W+1)'(tick_period);
        held_sum   = {1'b0, key_held_ms_reg} + (MS_W+1)'(tick_period);
        begin_el   = 1'b0;
        key_do     = 1'b0;
        key_dah    = 1'b0;
        dit_triple = '0;

        key_held_next    = key_held_reg;
        key_held_ms_next = key_held_ms_reg;
        running_next     = running_reg;
        stop_next        = stop_reg;
        mark_next        = mark_reg;
        paddle_kind_next = paddle_kind_reg;
        dit_next         = dit_reg;
        phase_next       = phase_reg;
        any_seen_next    = any_seen_reg;
        since_next       = since_reg;
        pat_next         = pat_reg;
        count_next       = count_reg;

        res_elem_valid = 1'b0;
        res_elem_dah   = 1'b0;
        res_chr_valid  = 1'b0;
        res_chr_pat    = '0;
        res_chr_len    = '0;

        // Decode the command
        unique case (op)
            CMD_TICK:
            begin
                since_next = since_sum[MS_W] ? '1 : since_sum[MS_W-1:0];
                if (key_held_reg)
                begin
                    key_held_ms_next = held_sum[MS_W] ? '1 : held_sum[MS_W-1:0];
                end
                else if (running_reg)
                begin
                    if (phase_reg <= PHASE_W'(tick_period))
                    begin
                        phase_next = '0;
                        if (mark_reg)
                        begin
                            mark_next  = 1'b0;
                            phase_next = PHASE_W'(dit_reg);
                        end
                        else if (stop_reg)
                        begin
                            running_next = 1'b0;
                            stop_next    = 1'b0;
                        end
                        else
                        begin
                            begin_el = 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next = phase_reg - PHASE_W'(tick_period);
                    end
                end
            end
            CMD_PADDLE_START:
            begin
                paddle_kind_next = item_kind_reg;
                if (!running_reg)
                begin
                    running_next = 1'b1;
                    stop_next    = 1'b0;
                    dit_next     = quo_dit[DIT_W-1:0];
                    begin_el     = 1'b1;
                end
            end
            CMD_PADDLE_STOP:
            begin
                if (running_reg)
                begin
                    stop_next = 1'b1;
                end
            end
            CMD_KEY_DOWN:
            begin
                key_held_next    = 1'b1;
                key_held_ms_next = '0;
            end
            CMD_KEY_UP:
            begin
                if (key_held_reg)
                begin
                    key_held_next = 1'b0;
                    key_do        = 1'b1;
                    key_dah       = (key_held_ms_reg >= dah_ms);
                end
            end
            CMD_ENTER:
            begin
                key_do  = 1'b1;
                key_dah = item_kind_reg;
            end
            CMD_FINISH:
            begin
            end
            default:
            begin
            end
        endcase

        // Start a paddle element: tone for one or three dits
        if (begin_el)
        begin
            key_do     = 1'b1;
            key_dah    = paddle_kind_next;
            mark_next  = 1'b1;
            dit_triple = {1'b0, dit_next, 1'b0} + {2'b0, dit_next};
            phase_next = paddle_kind_next ? dit_triple[PHASE_W-1:0]
                                          : PHASE_W'(dit_next);
        end

        // Key an element, closing a stale character first
        if (key_do)
        begin
            if (any_seen_next && (since_next > gap_ms) && (count_next != '0))
            begin
                res_chr_valid = 1'b1;
                res_chr_pat   = pat_next;
                res_chr_len   = count_next;
                pat_next      = '0;
                count_next    = '0;
            end
            if (count_next < CNT_W'(CAPACITY))
            begin
                if (key_dah && (count_next < CNT_W'(PAT_W)))
                begin
                    pat_next[count_next[PAT_IDX_W-1:0]] = 1'b1;
                end
                count_next = count_next + 1'b1;
            end
            any_seen_next  = 1'b1;
            since_next     = '0;
            res_elem_valid = 1'b1;
            res_elem_dah   = key_dah;
        end

        // End the character on a long gap or on finish
        if (((op == CMD_TICK) && any_seen_next && (since_next >= gap_ms)
             && (count_next != '0))
            || ((op == CMD_FINISH) && (count_next != '0)))
        begin
            res_chr_valid = 1'b1;
            res_chr_pat   = pat_next;
            res_chr_len   = count_next;
            pat_next      = '0;
            count_next    = '0;
        end

        // Tick reports tone at its start, events after the update
        if (op == CMD_TICK)
        begin
            res_tone = key_held_reg | (running_reg & mark_reg);
        end
        else
        begin
            res_tone = key_held_next | (running_next & mark_next);
        end
    end

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_cmd_reg  <= command;
            item_kind_reg <= element_kind;
        end
    end

    // Update keyer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_held_reg    <= 1'b0;
            key_held_ms_reg <= '0;
            running_reg     <= 1'b0;
            stop_reg        <= 1'b0;
            mark_reg        <= 1'b0;
            paddle_kind_reg <= 1'b0;
            dit_reg         <= DEFAULT_DIT;
            phase_reg       <= '0;
            any_seen_reg    <= 1'b0;
            since_reg       <= '0;
            pat_reg         <= '0;
            count_reg       <= '0;
        end
        else if (cmd.exec)
        begin
            key_held_reg    <= key_held_next;
            key_held_ms_reg <= key_held_ms_next;
            running_reg     <= running_next;
            stop_reg        <= stop_next;
            mark_reg        <= mark_next;
            paddle_kind_reg <= paddle_kind_next;
            dit_reg         <= dit_next;
            phase_reg       <= phase_next;
            any_seen_reg    <= any_seen_next;
            since_reg       <= since_next;
            pat_reg         <= pat_next;
            count_reg       <= count_next;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            tone_reg       <= res_tone;
            elem_valid_reg <= res_elem_valid;
            elem_dah_reg   <= res_elem_dah;
            chr_valid_reg  <= res_chr_valid;
            chr_pat_reg    <= res_chr_pat;
            chr_len_reg    <= res_chr_len;
        end
    end

    assign out_free       = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign tone_on        = tone_reg;
    assign element_valid  = elem_valid_reg;
    assign element_is_dah = elem_dah_reg;
    assign char_valid     = chr_valid_reg;
    assign char_pattern   = chr_pat_reg;
    assign char_length    = chr_len_reg;

endmodule

[sv/mket_ctrl.sv]
// ----------------------------------------------------------------------------
// mket_ctrl: keyer sequencer
// Takes one input word, runs the divider, then applies the word once the
// output register is free.
// ----------------------------------------------------------------------------
module mket_ctrl import mket_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ctrl_sts_t   sts,
    output ctrl_cmd_t   cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EXEC
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;
    logic   div_start_reg;

    // Sequence one word at a time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg     <= S_DIV;
                        in_ready_reg  <= 1'b0;
                        div_start_reg <= 1'b1;
                    end
                end
                S_DIV:
                begin
                    if (sts.div_done)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (sts.out_free)
                    begin
                        state_reg    <= S_IDLE;
                        in_ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg    <= S_IDLE;
                    in_ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign in_ready      = in_ready_reg;
    assign cmd.capture   = in_valid && in_ready_reg;
    assign cmd.div_start = div_start_reg;
    assign cmd.exec      = (state_reg == S_EXEC) && sts.out_free;

`ifndef SYNTH
    // A word is applied only while no new word can enter
    a_exec_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> !in_ready)
        else $error("exec while input ready");

    // Every captured word starts the divider next cycle
    a_capture_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.div_start)
        else $error("capture without divider start");

    // Divider completes only while the sequencer waits for it
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == S_DIV))
        else $error("divider done outside wait state");

    // Ready comes back only after a word was applied
    a_ready_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> $past(cmd.exec))
        else $error("ready raised without exec");
`endif

endmodule

[sv/morse_keyer_element_timer_unit.sv]
// ----------------------------------------------------------------------------
// morse_keyer_element_timer_unit: single-paddle and straight-key Morse keyer
// Keeps the keyer phase, key-held time, element gap and the dit/dah pattern
// of the character in progress; one result word per input word.
//
// Usage:
//   Input channel (in_valid/in_ready) carries command and element_kind:
//   ticks, paddle start/stop, key down/up, enter element, finish character.
//   Output channel (out_valid/out_ready) returns one word per input word:
//   tone_on, element_valid/element_is_dah, char_valid/char_pattern/length.
//   Registers over APB: 0x0 words_per_minute (0 means 15), 0x4
//   tick_period_ms; write them only while the block is idle.
//   Each word runs a 12-step restoring divider for 1200, 2400 and 3600
//   over the effective wpm, then an update step; the next word is
//   taken only after the previous one has been applied. The output
//   register holds a finished word while a new one is taken; if the
//   receiver stalls, the next word waits in its update step.
//   Reset clears the keyer state, restores wpm 15, tick 10 ms and a dit of
//   80 ms, and leaves in_ready high.
// ----------------------------------------------------------------------------
module morse_keyer_element_timer_unit import mket_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // APB configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // Input channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CMD_W-1:0]     command,
    input  logic                 element_kind,
    // Output channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 tone_on,
    output logic                 element_valid,
    output logic                 element_is_dah,
    output logic                 char_valid,
    output logic [PAT_W-1:0]     char_pattern,
    output logic [CNT_W-1:0]     char_length
);

    logic [WPM_W-1:0]  wpm_reg;
    logic [TICK_W-1:0] tick_reg;
    logic [WPM_W-1:0]  eff_wpm;
    logic              cfg_write;

    ctrl_cmd_t         cmd;
    ctrl_sts_t         sts;
    logic              div_done;
    logic              out_free;
    logic [DIV_W-1:0]  quo_dit;
    logic [DIV_W-1:0]  quo_dah;
    logic [DIV_W-1:0]  quo_gap;

    // Write configuration registers
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpm_reg  <= DEFAULT_WPM;
            tick_reg <= DEFAULT_TICK;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_WPM:  wpm_reg  <= pwdata[WPM_W-1:0];
                REG_TICK: tick_reg <= pwdata[TICK_W-1:0];
                default:  ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (paddr[2])
            REG_WPM:  prdata = {{(32-WPM_W){1'b0}}, wpm_reg};
            REG_TICK: prdata = {{(32-TICK_W){1'b0}}, tick_reg};
            default:  prdata = '0;
        endcase
    end

    // Substitute the default speed for zero
    assign eff_wpm = (wpm_reg == '0) ? DEFAULT_WPM : wpm_reg;

    assign sts.div_done = div_done;
    assign sts.out_free = out_free;

    mket_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mket_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .divisor (eff_wpm),
        .done    (div_done),
        .quo_dit (quo_dit),
        .quo_dah (quo_dah),
        .quo_gap (quo_gap)
    );

    mket_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .out_free       (out_free),
        .command        (command),
        .element_kind   (element_kind),
        .tick_period    (tick_reg),
        .quo_dit        (quo_dit),
        .quo_dah        (quo_dah),
        .quo_gap        (quo_gap),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .tone_on        (tone_on),
        .element_valid  (element_valid),
        .element_is_dah (element_is_dah),
        .char_valid     (char_valid),
        .char_pattern   (char_pattern),
        .char_length    (char_length)
    );

endmodule
